// ===== design/dams_pkg.sv =====
// Package: shared types and constants of the deep attenuation map splatter.
package dams_pkg;

    // Command codes
    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_LAYER_COUNT = 3'd2;
    localparam logic [2:0] REG_SPACING     = 3'd3;
    localparam logic [2:0] REG_EXPO        = 3'd4;

    localparam logic [31:0] DEPTH_EMPTY = 32'hFFFF_FFFF;

    // Input beat
    typedef struct packed {
        logic               command;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [31:0]        depth_in;
        logic [15:0]        atten_red;
        logic [15:0]        atten_green;
        logic [15:0]        atten_blue;
        logic [6:0]         read_column;
        logic [6:0]         read_row;
        logic [2:0]         read_layer;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [31:0] first_depth;
        logic [15:0] layer_red;
        logic [15:0] layer_green;
        logic [15:0] layer_blue;
    } out_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic               is_read;
        logic signed [17:0] px;
        logic signed [17:0] py;
        logic [7:0]         ax;
        logic [7:0]         ay;
        logic [31:0]        depth;
        logic [2:0][15:0]   atten;
        logic [6:0]         rcol;
        logic [6:0]         rrow;
        logic [2:0]         rlay;
    } item_t;

    // Configuration after clamping to the map maxima
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  layers;
        logic [31:0] spacing;
        logic        expo;
    } cfg_t;

endpackage

// ===== design/dams_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/dams_front.sv =====
// Front: accepts commands, splits sample coordinates, queues them for the back.
module dams_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dams_pkg::in_t  in_data,
    output logic           q_valid,
    output dams_pkg::item_t q_item,
    input  logic           pop
);
    import dams_pkg::*;

    item_t       item;
    item_t       q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic signed [24:0] tx, ty;

    // Coordinate minus one half: floor pixel and 0.8 fraction
    always_comb
    begin
        tx = 25'(in_data.pos_x) - 25'sd128;
        ty = 25'(in_data.pos_y) - 25'sd128;
        item.is_read = (in_data.command == CMD_READ);
        item.px      = 18'(tx >>> 8);
        item.py      = 18'(ty >>> 8);
        item.ax      = tx[7:0];
        item.ay      = ty[7:0];
        item.depth   = in_data.depth_in;
        item.atten   = {in_data.atten_red, in_data.atten_green, in_data.atten_blue};
        item.rcol    = in_data.read_column;
        item.rrow    = in_data.read_row;
        item.rlay    = in_data.read_layer;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    // Two-entry queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== design/dams_back.sv =====
// Back: sequences splats and reads over the depth and layer memories.
module dams_back #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_LAYERS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dams_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  dams_pkg::item_t q_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output dams_pkg::out_t  out_data
);
    import dams_pkg::*;

    localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int LDEP = MAX_LAYERS * PIX;
    localparam int XB   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PB   = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int LB   = (LDEP > 1) ? $clog2(LDEP) : 1;
    localparam int LIB  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_CORNER = 11'b000_0000_0100,
        S_ATTEN  = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_LOG    = 11'b000_0010_0000,
        S_LISS   = 11'b000_0100_0000,
        S_LWR    = 11'b000_1000_0000,
        S_RDATA  = 11'b001_0000_0000,
        S_SPARE0 = 11'b010_0000_0000,
        S_SPARE1 = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [1:0]         corner_reg, corner_next;
    logic [16:0]        w_reg, w_next;
    logic [2:0][15:0]   atn_reg, atn_next;
    logic [PB-1:0]      idx_reg, idx_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        num_reg, num_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [LIB-1:0]     lay_reg, lay_next;
    logic [32:0]        v_reg, v_next;
    logic [LB:0]        clr_reg, clr_next;
    logic               rd_in_reg, rd_in_next;
    logic               rd_lay_reg, rd_lay_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    // Memory ports
    logic               d_we, d_re, l_we, l_re;
    logic [PB-1:0]      d_waddr, d_raddr;
    logic [LB-1:0]      l_waddr, l_raddr;
    logic [31:0]        d_wdata, d_rdata;
    logic [47:0]        l_wdata, l_rdata;

    // Working values
    logic signed [17:0] cx, cy;
    logic [8:0]         wx, wy;
    logic               c_in;
    logic [31:0]        sp, zc, zref, off;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [31:0]        quo_n;
    logic [7:0]         nm1;
    logic               out_free;
    logic               r_in, r_lay;
    logic [PB-1:0]      r_idx;
    logic [33:0]        prod_a [3];
    logic [32:0]        prod_b [3];
    logic [17:0]        sum_b [3];
    logic [15:0]        dv [3];
    logic [15:0]        blend [3];

    dams_ram #(.WIDTH(32), .DEPTH(PIX)) u_depth_ram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
    );

    dams_ram #(.WIDTH(48), .DEPTH(LDEP)) u_layer_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Corner position, weight factors and bounds
    always_comb
    begin
        cx   = item_reg.px + 18'(corner_reg[0]);
        cy   = item_reg.py + 18'(corner_reg[1]);
        wx   = corner_reg[0] ? {1'b0, item_reg.ax} : 9'd256 - {1'b0, item_reg.ax};
        wy   = corner_reg[1] ? {1'b0, item_reg.ay} : 9'd256 - {1'b0, item_reg.ay};
        c_in = !cx[17] && !cy[17] && (cx[16:0] < {1'b0, cfg.width})
               && (cy[16:0] < {1'b0, cfg.height});
    end

    // Depth clamp, divider step, weighted channels and blend lanes
    always_comb
    begin
        sp   = (cfg.spacing == 32'd0) ? 32'd1 : cfg.spacing;
        zc   = item_reg.depth;
        zref = d_rdata;
        if (d_rdata == DEPTH_EMPTY)
        begin
            zref = item_reg.depth;
        end
        else if (item_reg.depth < d_rdata)
        begin
            zc = d_rdata;
        end
        off    = zc - zref;
        rem_sh = {rem_reg[31:0], num_reg[31]};
        ge     = (rem_sh >= {1'b0, sp});
        quo_n  = {quo_reg[30:0], ge};
        nm1    = cfg.layers - 8'd1;
        for (int c = 0; c < 3; c++)
        begin
            prod_a[c] = 34'(item_reg.atten[c]) * 34'(w_reg) + 34'd32768;
            dv[c]     = l_rdata[16*c +: 16];
            prod_b[c] = (33'd65536 - 33'(dv[c])) * 33'(atn_reg[c]);
            sum_b[c]  = 18'(dv[c]) + 18'(prod_b[c][32:16]);
            blend[c]  = (sum_b[c] > 18'd65535) ? 16'hFFFF : sum_b[c][15:0];
        end
    end

    // Read command address and range checks
    always_comb
    begin
        r_in  = ({9'd0, q_item.rcol} < cfg.width) && ({9'd0, q_item.rrow} < cfg.height);
        r_lay = ({5'd0, q_item.rlay} < cfg.layers);
        r_idx = PB'(q_item.rrow) * PB'(MAX_WIDTH) + PB'(q_item.rcol);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        corner_next    = corner_reg;
        w_next         = w_reg;
        atn_next       = atn_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        lay_next       = lay_reg;
        v_next         = v_reg;
        clr_next       = clr_reg;
        rd_in_next     = rd_in_reg;
        rd_lay_next    = rd_lay_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        d_we           = 1'b0;
        d_waddr        = idx_reg;
        d_wdata        = item_reg.depth;
        d_re           = 1'b0;
        d_raddr        = idx_reg;
        l_we           = 1'b0;
        l_waddr        = LB'(lay_reg) * LB'(PIX) + LB'(idx_reg);
        l_wdata        = {blend[2], blend[1], blend[0]};
        l_re           = 1'b0;
        l_raddr        = LB'(lay_reg) * LB'(PIX) + LB'(idx_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                l_we    = 1'b1;
                l_waddr = clr_reg[LB-1:0];
                l_wdata = 48'd0;
                d_we    = (clr_reg < (LB+1)'(PIX));
                d_waddr = clr_reg[PB-1:0];
                d_wdata = DEPTH_EMPTY;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (LB+1)'(LDEP - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    item_next   = q_item;
                    corner_next = 2'd0;
                    if (q_item.is_read)
                    begin
                        rd_in_next  = r_in;
                        rd_lay_next = r_in && r_lay;
                        d_re        = r_in;
                        d_raddr     = r_idx;
                        l_re        = r_in && r_lay;
                        l_raddr     = LB'(q_item.rlay) * LB'(PIX) + LB'(r_idx);
                        state_next  = S_RDATA;
                    end
                    else
                    begin
                        state_next = S_CORNER;
                    end
                end
            end
            S_CORNER:
            begin
                if (c_in)
                begin
                    w_next     = 17'(wx * wy);
                    idx_next   = PB'(cy[YB-1:0]) * PB'(MAX_WIDTH) + PB'(cx[XB-1:0]);
                    d_re       = 1'b1;
                    d_raddr    = PB'(cy[YB-1:0]) * PB'(MAX_WIDTH) + PB'(cx[XB-1:0]);
                    state_next = S_ATTEN;
                end
                else if (corner_reg == 2'd3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                end
            end
            S_ATTEN:
            begin
                // Weighted channels; empty pixel takes the sample depth
                for (int c = 0; c < 3; c++)
                begin
                    atn_next[c] = prod_a[c][31:16];
                end
                d_we       = (d_rdata == DEPTH_EMPTY);
                rem_next   = 33'd0;
                quo_next   = 32'd0;
                num_next   = off;
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? rem_sh - {1'b0, sp} : rem_sh;
                quo_next = quo_n;
                num_next = {num_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (cfg.layers == 8'd0)
                    begin
                        if (corner_reg == 2'd3)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            corner_next = corner_reg + 2'd1;
                            state_next  = S_CORNER;
                        end
                    end
                    else if (cfg.expo)
                    begin
                        v_next     = {1'b0, quo_n} + 33'd1;
                        lay_next   = '0;
                        state_next = S_LOG;
                    end
                    else
                    begin
                        lay_next   = (quo_n >= 32'(nm1)) ? LIB'(nm1) : LIB'(quo_n);
                        state_next = S_LISS;
                    end
                end
            end
            S_LOG:
            begin
                // One bit of floor log2 per cycle, stops at the last layer
                if ((v_reg > 33'd1) && (8'(lay_reg) < nm1))
                begin
                    v_next   = v_reg >> 1;
                    lay_next = lay_reg + 1'b1;
                end
                else
                begin
                    state_next = S_LISS;
                end
            end
            S_LISS:
            begin
                l_re       = 1'b1;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                l_we = 1'b1;
                if (8'(lay_reg) == nm1)
                begin
                    if (corner_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        state_next  = S_CORNER;
                    end
                end
                else
                begin
                    lay_next   = lay_reg + 1'b1;
                    state_next = S_LISS;
                end
            end
            S_RDATA:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.first_depth = rd_in_reg ? d_rdata : DEPTH_EMPTY;
                    out_data_next.layer_red   = rd_lay_reg ? l_rdata[47:32] : 16'd0;
                    out_data_next.layer_green = rd_lay_reg ? l_rdata[31:16] : 16'd0;
                    out_data_next.layer_blue  = rd_lay_reg ? l_rdata[15:0] : 16'd0;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            corner_reg    <= 2'd0;
            cnt_reg       <= 5'd0;
            lay_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            corner_reg    <= corner_next;
            cnt_reg       <= cnt_next;
            lay_reg       <= lay_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        w_reg        <= w_next;
        atn_reg      <= atn_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        num_reg      <= num_next;
        v_reg        <= v_next;
        rd_in_reg    <= rd_in_next;
        rd_lay_reg   <= rd_lay_next;
        out_data_reg <= out_data_next;
    end
endmodule

// ===== design/deep_attenuation_map_splat_top.sv =====
// Top level of the deep attenuation map splatter: config registers, front and back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data (in_t)
//   out     | output    | out_valid/out_stall| out_data (out_t)
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A read pops the queue with its memory fetch, then loads the output
// register, where any output stall holds it. A splat handles each corner
// inside the map with the corner and depth-fetch states and a 32-step
// restoring divider, in log mode then the log steps, and a read and then a
// write of the layer memory per blended layer; corners outside the map are
// passed over. After reset a clearing pass over the depth and layer memories
// runs before the first command; the two-entry queue still takes beats
// meanwhile. A stalled output holds the back only when it has a read result
// to deliver.
module deep_attenuation_map_splat_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_LAYERS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dams_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output dams_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import dams_pkg::*;

    logic [7:0]  map_width_reg, map_height_reg;
    logic [3:0]  layer_count_reg;
    logic [31:0] spacing_reg;
    logic        expo_reg;
    cfg_t        cfg;
    logic        q_valid, pop;
    item_t       q_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= 8'd128;
            map_height_reg  <= 8'd128;
            layer_count_reg <= 4'd8;
            spacing_reg     <= 32'd65536;
            expo_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[7:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[7:0];
                REG_LAYER_COUNT: layer_count_reg <= cfg_data[3:0];
                REG_SPACING:     spacing_reg     <= cfg_data;
                REG_EXPO:        expo_reg        <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Clamp to the map maxima
    always_comb
    begin
        cfg.width   = (32'(map_width_reg) > 32'(MAX_WIDTH)) ? 16'(MAX_WIDTH)
                                                              : 16'(map_width_reg);
        cfg.height  = (32'(map_height_reg) > 32'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                                : 16'(map_height_reg);
        cfg.layers  = (32'(layer_count_reg) > 32'(MAX_LAYERS)) ? 8'(MAX_LAYERS)
                                                                 : 8'(layer_count_reg);
        cfg.spacing = spacing_reg;
        cfg.expo    = expo_reg;
    end

    dams_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_item(q_item), .pop(pop)
    );

    dams_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_LAYERS(MAX_LAYERS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .q_valid(q_valid), .q_item(q_item), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// ===== tb/tb_deep_attenuation_map_splat_top.sv =====
// Testbench for the deep attenuation map splatter: random splats and reads against a local model.
`timescale 1ns / 1ps

module tb_deep_attenuation_map_splat_top;
    import dams_pkg::*;

    localparam int          MAP_W      = 128;
    localparam int          MAP_H      = 128;
    localparam int          MAP_L      = 8;
    localparam int          PIXELS     = MAP_W * MAP_H;
    localparam logic [2:0]  REG_UNUSED = 3'd5;
    localparam int          DRAIN      = 2000;
    localparam longint      LIMIT      = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    deep_attenuation_map_splat_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Model state: registers and the two stores
    logic [7:0]  m_width;
    logic [7:0]  m_height;
    logic [3:0]  m_layers;
    logic [31:0] m_spacing;
    logic        m_expo;
    logic [31:0] depth_mem [0:PIXELS-1];
    logic [15:0] atten_mem [0:MAP_L*PIXELS-1][0:2];

    in_t  pending_beats [$];
    out_t pixel_reads [$];
    int   err_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    longint cycle_count = 0;

    function automatic int clamp_to(int v, int m);
        return v > m ? m : v;
    endfunction

    // Blend one weighted sample into a pixel's layers
    function automatic void blend_pixel(int col, int row, logic [31:0] z, longint a [3]);
        int          idx;
        logic [31:0] ref_z;
        logic [31:0] q;
        longint      v;
        int          lay;
        int          n;
        longint      dv;
        longint      r;
        idx = row * MAP_W + col;
        if (depth_mem[idx] == DEPTH_EMPTY) begin
            depth_mem[idx] = z;
            ref_z = z;
        end
        else begin
            ref_z = depth_mem[idx];
            if (z < ref_z)
                z = ref_z;
        end
        q = (z - ref_z) / ((m_spacing == 0) ? 32'd1 : m_spacing);
        if (m_expo) begin
            v = longint'(q) + 1;
            lay = 0;
            while (v > 1) begin
                v = v >> 1;
                lay++;
            end
        end
        else begin
            lay = (q > 32'd1000) ? 1000 : int'(q);
        end
        n = clamp_to(int'(m_layers), MAP_L);
        if (n == 0)
            return;
        if (lay >= n)
            lay = n - 1;
        for (int l = lay; l < n; l++) begin
            for (int c = 0; c < 3; c++) begin
                dv = longint'(atten_mem[l*PIXELS+idx][c]);
                r = dv + (((65536 - dv) * a[c]) >> 16);
                atten_mem[l*PIXELS+idx][c] = (r > 65535) ? 16'hFFFF : r[15:0];
            end
        end
    endfunction

    function automatic void splat_corner(int px, int py, longint w, logic [31:0] z, in_t b);
        longint a [3];
        if (px < 0 || py < 0 || px >= clamp_to(int'(m_width), MAP_W)
                || py >= clamp_to(int'(m_height), MAP_H))
            return;
        a[0] = (longint'(b.atten_red) * w + 32768) >> 16;
        a[1] = (longint'(b.atten_green) * w + 32768) >> 16;
        a[2] = (longint'(b.atten_blue) * w + 32768) >> 16;
        blend_pixel(px, py, z, a);
    endfunction

    // Update the model for one accepted command; reads queue their pixel
    function automatic void apply_command(in_t b);
        int   tx;
        int   ty;
        int   px;
        int   py;
        int   ax;
        int   ay;
        int   idx;
        out_t res;
        if (b.command == CMD_SPLAT) begin
            tx = int'(b.pos_x) - 128;
            ty = int'(b.pos_y) - 128;
            px = tx >>> 8;
            py = ty >>> 8;
            ax = tx & 255;
            ay = ty & 255;
            splat_corner(px, py, (256 - ax) * (256 - ay), b.depth_in, b);
            splat_corner(px + 1, py, ax * (256 - ay), b.depth_in, b);
            splat_corner(px, py + 1, (256 - ax) * ay, b.depth_in, b);
            splat_corner(px + 1, py + 1, ax * ay, b.depth_in, b);
        end
        else begin
            res = '0;
            res.first_depth = DEPTH_EMPTY;
            if (int'(b.read_column) < clamp_to(int'(m_width), MAP_W)
                    && int'(b.read_row) < clamp_to(int'(m_height), MAP_H)) begin
                idx = int'(b.read_row) * MAP_W + int'(b.read_column);
                res.first_depth = depth_mem[idx];
                if (int'(b.read_layer) < clamp_to(int'(m_layers), MAP_L)) begin
                    res.layer_red   = atten_mem[int'(b.read_layer)*PIXELS+idx][0];
                    res.layer_green = atten_mem[int'(b.read_layer)*PIXELS+idx][1];
                    res.layer_blue  = atten_mem[int'(b.read_layer)*PIXELS+idx][2];
                end
            end
            pixel_reads.push_back(res);
        end
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n) begin
        logic fire;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            fire = in_valid && !in_stall;
            if (fire)
                apply_command(in_data);
            if (!in_valid || fire) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        out_t exp_beat;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pixel_reads.size() == 0) begin
                    $error("unexpected result beat %h", out_data);
                    err_count++;
                end
                else begin
                    exp_beat = pixel_reads.pop_front();
                    if (out_data.first_depth !== exp_beat.first_depth) begin
                        $error("first_depth: expected %h, got %h",
                               exp_beat.first_depth, out_data.first_depth);
                        err_count++;
                    end
                    if (out_data.layer_red !== exp_beat.layer_red) begin
                        $error("layer_red: expected %h, got %h",
                               exp_beat.layer_red, out_data.layer_red);
                        err_count++;
                    end
                    if (out_data.layer_green !== exp_beat.layer_green) begin
                        $error("layer_green: expected %h, got %h",
                               exp_beat.layer_green, out_data.layer_green);
                        err_count++;
                    end
                    if (out_data.layer_blue !== exp_beat.layer_blue) begin
                        $error("layer_blue: expected %h, got %h",
                               exp_beat.layer_blue, out_data.layer_blue);
                        err_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:   m_width   = val[7:0];
            REG_MAP_HEIGHT:  m_height  = val[3:0] == 0 && val[7:0] == 0 ? 8'd0 : val[7:0];
            REG_LAYER_COUNT: m_layers  = val[3:0];
            REG_SPACING:     m_spacing = val;
            REG_EXPO:        m_expo    = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || pixel_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic in_t make_splat(int x, int y, logic [31:0] z, logic [15:0] r,
                                       logic [15:0] g, logic [15:0] b);
        in_t s;
        s = '0;
        s.command     = CMD_SPLAT;
        s.pos_x       = 24'(x);
        s.pos_y       = 24'(y);
        s.depth_in    = z;
        s.atten_red   = r;
        s.atten_green = g;
        s.atten_blue  = b;
        return s;
    endfunction

    function automatic in_t make_read(int col, int row, int lay);
        in_t s;
        s = '0;
        s.command     = CMD_READ;
        s.read_column = 7'(col);
        s.read_row    = 7'(row);
        s.read_layer  = 3'(lay);
        return s;
    endfunction

    // One random beat, mostly aimed at the map in use
    function automatic in_t random_beat(logic [31:0] base_z);
        in_t    s;
        int     wd;
        int     ht;
        longint span;
        wd = clamp_to(int'(m_width), MAP_W);
        ht = clamp_to(int'(m_height), MAP_H);
        if ($urandom_range(99) < 35) begin
            s = make_read($urandom_range(wd + 1), $urandom_range(ht + 1), $urandom_range(7));
            if ($urandom_range(9) == 0) begin
                s = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
                s.read_column = 7'($urandom);
                s.read_row    = 7'($urandom);
                s.command     = CMD_READ;
            end
            return s;
        end
        span = longint'((m_spacing == 0) ? 32'd1 : m_spacing) * 12;
        s = make_splat(int'($urandom_range((wd + 2) * 256)) - 256,
                       int'($urandom_range((ht + 2) * 256)) - 256,
                       (span > 32'h7FFF_FFFF) ? $urandom
                           : base_z + $urandom_range(32'(span)),
                       16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(9) == 0) begin
            s.pos_x = 24'($urandom);
            s.pos_y = 24'($urandom);
        end
        if ($urandom_range(19) == 0)
            s.depth_in = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : $urandom;
        // unused fields of a splat carry noise
        s.read_column = 7'($urandom);
        s.read_row    = 7'($urandom);
        s.read_layer  = 3'($urandom);
        return s;
    endfunction

    task automatic run_phase(int count, int idle_mode, logic [31:0] base_z);
        for (int i = 0; i < count; i++)
            pending_beats.push_back(random_beat(base_z));
        // idle modes: none, sender, receiver, both, mixed
        while (pending_beats.size() != 0) begin
            case (idle_mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin
                    send_idle_pct  = ($urandom_range(1) == 1) ? 73 : 0;
                    recv_stall_pct = ($urandom_range(1) == 1) ? 73 : 0;
                end
            endcase
            repeat ($urandom_range(50, 400)) @(posedge clk);
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < PIXELS; i++)
            depth_mem[i] = DEPTH_EMPTY;
        for (int i = 0; i < MAP_L * PIXELS; i++)
            for (int c = 0; c < 3; c++)
                atten_mem[i][c] = '0;
        m_width   = 8'd128;
        m_height  = 8'd128;
        m_layers  = 4'd8;
        m_spacing = 32'd65536;
        m_expo    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners of the field ranges and the special cases
        pending_beats.push_back(make_splat(0, 0, 32'h0001_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_beats.push_back(make_splat(128, 128, 32'h0000_8000, 16'h8000, 16'h0, 16'hFFFF));
        pending_beats.push_back(make_splat(128, 128, 32'h0005_0000, 16'h4000, 16'h1234, 16'h0));
        pending_beats.push_back(make_splat(-8388608, -8388608, 32'h0, 16'hFFFF, 16'h1, 16'h2));
        pending_beats.push_back(make_splat(8388607, 8388607, 32'h1, 16'hFFFF, 16'hFFFF, 16'h1));
        pending_beats.push_back(make_splat(127 * 256 + 200, 127 * 256 + 200, 32'hFFFF_FFFE,
                                           16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_beats.push_back(make_splat(10 * 256 + 128, 20 * 256 + 128, 32'hFFFF_FFFF,
                                           16'hAAAA, 16'h5555, 16'hFFFF));
        pending_beats.push_back(make_splat(10 * 256 + 128, 20 * 256 + 128, 32'h0,
                                           16'h5555, 16'hAAAA, 16'h0));
        pending_beats.push_back(make_splat(3 * 256 + 64, 3 * 256 + 192, 32'h0010_0000,
                                           16'h7FFF, 16'h8000, 16'h0001));
        pending_beats.push_back(make_splat(3 * 256 + 64, 3 * 256 + 192, 32'h0002_0000,
                                           16'h7FFF, 16'h8000, 16'h0001));
        pending_beats.push_back(make_splat(3 * 256 + 64, 3 * 256 + 192, 32'h00FF_0000,
                                           16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int l = 0; l < 8; l++)
            pending_beats.push_back(make_read(3, 3, l));
        pending_beats.push_back(make_read(0, 0, 0));
        pending_beats.push_back(make_read(127, 127, 7));
        pending_beats.push_back(make_read(10, 20, 0));
        pending_beats.push_back(make_read(50, 60, 3));
        run_phase(150, 0, 32'h0001_0000);

        // Small map, linear layers
        write_reg(REG_MAP_WIDTH, 32'd8);
        write_reg(REG_MAP_HEIGHT, 32'd6);
        write_reg(REG_LAYER_COUNT, 32'd4);
        write_reg(REG_SPACING, 32'h0000_4000);
        write_reg(REG_EXPO, 32'd0);
        run_phase(200, 1, 32'h0020_0000);

        // Exponential layers, tight spacing
        write_reg(REG_MAP_WIDTH, 32'd16);
        write_reg(REG_MAP_HEIGHT, 32'd16);
        write_reg(REG_LAYER_COUNT, 32'd8);
        write_reg(REG_SPACING, 32'h0000_0100);
        write_reg(REG_EXPO, 32'hFFFF_FFFF);
        run_phase(200, 2, 32'h0000_0000);

        // Oversized registers saturate; zero spacing acts as one
        write_reg(REG_MAP_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_MAP_HEIGHT, 32'd200);
        write_reg(REG_LAYER_COUNT, 32'd15);
        write_reg(REG_SPACING, 32'd0);
        run_phase(150, 3, 32'h8000_0000);

        // Zero width and zero layers: splats land nowhere, reads are outside
        write_reg(REG_MAP_WIDTH, 32'd0);
        write_reg(REG_MAP_HEIGHT, 32'd5);
        write_reg(REG_LAYER_COUNT, 32'd0);
        write_reg(REG_SPACING, 32'hFFFF_FFFF);
        write_reg(REG_EXPO, 32'd0);
        run_phase(60, 0, 32'h0);

        // Zero layers on a live map: depths move, layers stay
        write_reg(REG_MAP_WIDTH, 32'd6);
        write_reg(REG_MAP_HEIGHT, 32'd0);
        run_phase(30, 4, 32'h0);
        write_reg(REG_MAP_HEIGHT, 32'd6);
        run_phase(120, 4, 32'h0040_0000);

        // Single pixel, single layer, one LSB spacing
        write_reg(REG_MAP_WIDTH, 32'd1);
        write_reg(REG_MAP_HEIGHT, 32'd1);
        write_reg(REG_LAYER_COUNT, 32'd1);
        write_reg(REG_SPACING, 32'd1);
        run_phase(120, 4, 32'h1000_0000);

        // Tall narrow map; out-of-range register writes are ignored
        write_reg(REG_MAP_WIDTH, 32'd5);
        write_reg(REG_MAP_HEIGHT, 32'd128);
        write_reg(REG_LAYER_COUNT, 32'd8);
        write_reg(REG_SPACING, 32'h0002_0000);
        write_reg(REG_UNUSED, 32'h0000_0001);
        write_reg(3'd7, 32'hFFFF_FFFF);
        run_phase(300, 4, 32'h0003_0000);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dams_pkg.sv
design/dams_ram.sv
design/dams_front.sv
design/dams_back.sv
design/deep_attenuation_map_splat_top.sv
tb/tb_deep_attenuation_map_splat_top.sv
